@@ rtl/ksd_pkg.sv @@
// Package: key sequence table, field widths and result codes for the key decoder.
`timescale 1ns / 1ps

package ksd_pkg;

    localparam int MAX_SEQ_LEN   = 6;
    localparam int TABLE_ENTRIES = 44;
    localparam int LEN_W         = $clog2(MAX_SEQ_LEN + 1);
    localparam int KEY_W         = 8;
    localparam int STATUS_W      = 2;
    localparam int ACTION_W      = 6;
    localparam int COUNT_W       = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [KEY_W-1:0]   CHAR_ZERO = 8'h30;
    localparam logic [KEY_W-1:0]   CHAR_NINE = 8'h39;

    localparam logic [STATUS_W-1:0] ST_PENDING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MATCH   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIGIT   = 2'd3;

    typedef logic [0:MAX_SEQ_LEN-1][KEY_W-1:0] t_key_seq;

    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [ACTION_W-1:0] act;
        t_key_seq            seq;
    } t_key_entry;

    // Byte strings, first byte leftmost; unused tail bytes are zero.
    localparam t_key_entry KEY_TABLE [TABLE_ENTRIES] = '{
        '{3'd1,  6'd0, {8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2,  6'd1, {8'h5b, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2,  6'd2, {8'h5b, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1,  6'd3, {8'h6b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2,  6'd4, {8'h5b, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2,  6'd5, {8'h5b, 8'h48, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd6,  6'd6, {8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h32, 8'h43}},
        '{3'd2,  6'd7, {8'h5b, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd6,  6'd8, {8'h1b, 8'h5b, 8'h31, 8'h3b, 8'h32, 8'h44}},
        '{3'd1,  6'd9, {8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd10, {8'h5b, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd11, {8'h7a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd12, {8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd13, {8'h4f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd3, 6'd14, {8'h1b, 8'h5b, 8'h42, 8'h00, 8'h00, 8'h00}},
        '{3'd3,  6'd7, {8'h1b, 8'h5b, 8'h46, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd15, {8'h63, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd16, {8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd5,  6'd6, {8'h5b, 8'h31, 8'h3b, 8'h32, 8'h43, 8'h00}},
        '{3'd2, 6'd17, {8'h63, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd18, {8'h79, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd19, {8'h0a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd5,  6'd8, {8'h5b, 8'h31, 8'h3b, 8'h32, 8'h44, 8'h00}},
        '{3'd1, 6'd20, {8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd21, {8'h79, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd22, {8'h63, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd23, {8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd24, {8'h64, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd3, 6'd25, {8'h1b, 8'h5b, 8'h43, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd26, {8'h78, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd3,  6'd9, {8'h1b, 8'h5b, 8'h44, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd27, {8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd28, {8'h67, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd29, {8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd30, {8'h5c, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1,  6'd8, {8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd31, {8'h79, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd3,  6'd5, {8'h1b, 8'h5b, 8'h48, 8'h00, 8'h00, 8'h00}},
        '{3'd1,  6'd6, {8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd3,  6'd3, {8'h1b, 8'h5b, 8'h41, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd32, {8'h63, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd14, {8'h6a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd2, 6'd33, {8'h61, 8'h0a, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{3'd1, 6'd25, {8'h6c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}}
    };

endpackage

@@ rtl/key_sequence_decoder_top.sv @@
// Top level: vi-style key sequence decoder with repeat count, one key byte per transfer.
`timescale 1ns / 1ps

// Decodes one keyboard byte per transfer and returns exactly one result per byte:
// pending, action matched (with action id), no match, or digit accumulated, together
// with the repeat count. Decimal digits typed while no sequence is pending build a
// count that saturates at 65535. A key byte passes through an input register, is
// compared against all 44 table strings at once, and lands in the result register. The
// block takes a new byte every cycle while the result side keeps up. The rate is set by
// the combinational parallel table compare and first-match select between the two
// registers.
module key_sequence_decoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ksd_pkg::KEY_W-1:0]      i_key_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ksd_pkg::STATUS_W-1:0]   o_status,
    output logic [ksd_pkg::ACTION_W-1:0]   o_action,
    output logic [ksd_pkg::COUNT_W-1:0]    o_repeat_count
);
    import ksd_pkg::*;

    // input stage
    logic                r_in_valid;
    logic [KEY_W-1:0]    r_in_key;

    // decoder state
    logic [KEY_W-1:0]    r_buf [MAX_SEQ_LEN];
    logic [LEN_W-1:0]    r_len;
    logic [COUNT_W-1:0]  r_count;
    logic [LEN_W-1:0]    n_len;
    logic [COUNT_W-1:0]  n_count;
    logic                buf_we;

    // result stage
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ACTION_W-1:0] r_action;
    logic [COUNT_W-1:0]  r_repeat;
    logic [STATUS_W-1:0] n_status;
    logic [ACTION_W-1:0] n_action;
    logic [COUNT_W-1:0]  n_repeat;

    logic advance;
    logic in_take;

    // compare logic
    t_key_seq            cand;
    logic [LEN_W-1:0]    new_len;
    logic [TABLE_ENTRIES-1:0] hit;
    logic                found;
    logic [LEN_W-1:0]    sel_len;
    logic [ACTION_W-1:0] sel_act;
    logic [COUNT_W+3:0]  count_x10;
    logic                is_digit;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign in_take = i_valid && !o_stall;
    assign o_stall = r_in_valid && !advance;

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_action       = r_action;
    assign o_repeat_count = r_repeat;

    assign new_len  = r_len + LEN_W'(1);
    assign is_digit = (r_in_key inside {[CHAR_ZERO:CHAR_NINE]});

    // Buffer as it would look with the new byte appended at position r_len.
    always_comb begin
        for (int i = 0; i < MAX_SEQ_LEN; i++) begin
            cand[i] = (LEN_W'(i) == r_len) ? r_in_key : r_buf[i];
        end
    end

    // Prefix compare against every entry; only positions below new_len count.
    always_comb begin
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            hit[e] = (new_len <= KEY_TABLE[e].len);
            for (int i = 0; i < MAX_SEQ_LEN; i++) begin
                if (LEN_W'(i) < new_len && cand[i] != KEY_TABLE[e].seq[i]) begin
                    hit[e] = 1'b0;
                end
            end
        end
    end

    // First hit in table order wins.
    always_comb begin
        found   = 1'b0;
        sel_len = '0;
        sel_act = '0;
        for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
            if (hit[e]) begin
                found   = 1'b1;
                sel_len = KEY_TABLE[e].len;
                sel_act = KEY_TABLE[e].act;
            end
        end
    end

    // count * 10 + digit; digit value is the low nibble of an ASCII digit
    assign count_x10 = ({4'b0, r_count} << 3) + ({4'b0, r_count} << 1)
                     + {{COUNT_W{1'b0}}, r_in_key[3:0]};

    always_comb begin
        n_len    = r_len;
        n_count  = r_count;
        buf_we   = 1'b0;
        n_status = ST_NOMATCH;
        n_action = '0;
        n_repeat = r_count;
        if (r_len == '0 && is_digit) begin
            n_count  = (count_x10 > {4'b0, COUNT_MAX}) ? COUNT_MAX : count_x10[COUNT_W-1:0];
            n_status = ST_DIGIT;
            n_repeat = n_count;
        end else if (r_len >= LEN_W'(MAX_SEQ_LEN)) begin
            n_len   = '0;
            n_count = '0;
        end else begin
            buf_we = 1'b1;
            if (found && sel_len != new_len) begin
                n_status = ST_PENDING;
                n_len    = new_len;
            end else if (found) begin
                n_status = ST_MATCH;
                n_action = sel_act;
                n_len    = '0;
                n_count  = '0;
            end else begin
                n_len   = '0;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_count     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_len       <= n_len;
                r_count     <= n_count;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_key <= i_key_byte;
        end
        if (advance) begin
            r_status <= n_status;
            r_action <= n_action;
            r_repeat <= n_repeat;
        end
        for (int i = 0; i < MAX_SEQ_LEN; i++) begin
            if (advance && buf_we && LEN_W'(i) == r_len) begin
                r_buf[i] <= r_in_key;
            end
        end
    end

endmodule
